>>> design/rptm_pkg.sv
// ----------------------------------------------------------------------------
// rptm_pkg
// Shared constants, types and register codes for the RC pulse trimmed-mean
// filter.
// ----------------------------------------------------------------------------
package rptm_pkg;

    localparam int WINDOW_DEPTH = 4;
    localparam int NumCh        = 6;
    localparam int PulseW       = 16;
    localparam int DataW        = 12;
    localparam int CfgIdxW      = 8;
    localparam int SlotW        = $clog2(WINDOW_DEPTH);
    localparam int SumW         = DataW + $clog2(WINDOW_DEPTH);

    // trimmed sum is divided by (depth - 2): shift when a power of two,
    // otherwise multiply by a rounded-up reciprocal (exact for SumW <= 15)
    localparam int TrimDiv    = WINDOW_DEPTH - 2;
    localparam bit TrimPow2   = ((TrimDiv & (TrimDiv - 1)) == 0);
    localparam int TrimShift  = $clog2(TrimDiv);
    localparam int RecipShift = 20;
    localparam int RecipW     = RecipShift + 1;
    localparam int TrimRecip  = ((1 << RecipShift) + TrimDiv - 1) / TrimDiv;
    localparam int ProdW      = SumW + RecipW;

    localparam logic [DataW-1:0] MeanMax         = '1;
    localparam logic [DataW-1:0] ValidMinReset   = DataW'(800);
    localparam logic [DataW-1:0] ValidMaxReset   = DataW'(2800);
    localparam logic [DataW-1:0] ModeLowReset    = DataW'(1200);
    localparam logic [DataW-1:0] ModeHighReset   = DataW'(1800);

    // receiver channel order
    localparam int CH_ROLL     = 0;
    localparam int CH_PITCH    = 1;
    localparam int CH_THROTTLE = 2;
    localparam int CH_YAW      = 3;
    localparam int CH_AUX1     = 4;
    localparam int CH_AUX2     = 5;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_VALID_MIN = 8'd0,
        CFG_VALID_MAX = 8'd1,
        CFG_MODE_LOW  = 8'd2,
        CFG_MODE_HIGH = 8'd3
    } t_cfg_reg;

    typedef logic [DataW-1:0] t_sample;

    typedef struct packed {
        t_sample valid_min;
        t_sample valid_max;
        t_sample mode_low;
        t_sample mode_high;
    } t_cfg;

    typedef struct packed {
        t_sample roll;
        t_sample pitch;
        t_sample yaw;
        t_sample throttle;
        t_sample aux1;
        t_sample aux2;
        logic    flight_mode;
    } t_result;

endpackage

>>> design/rptm_lane.sv
// ----------------------------------------------------------------------------
// rptm_lane
// One channel: window check with hold-last, sample ring, trimmed mean of the
// ring as it stands after this frame's write.
// ----------------------------------------------------------------------------
module rptm_lane import rptm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [SlotW-1:0]  i_slot,
    input  t_cfg              i_cfg,
    input  logic [PulseW-1:0] i_pulse,
    output t_sample           o_mean
);

    t_sample r_ring [WINDOW_DEPTH];
    t_sample r_last;

    logic             w_in_win;
    t_sample          w_sel;
    t_sample          w_view [WINDOW_DEPTH];
    t_sample          w_hi;
    t_sample          w_lo;
    logic [SumW-1:0]  w_sum;
    logic [SumW-1:0]  w_diff;
    logic [ProdW-1:0] w_prod;
    logic [SumW-1:0]  w_quot;

    always_comb begin
        w_in_win = (i_pulse >= PulseW'(i_cfg.valid_min))
                && (i_pulse <= PulseW'(i_cfg.valid_max));
        w_sel    = w_in_win ? i_pulse[DataW-1:0] : r_last;

        // ring contents with the new sample already in its slot
        w_hi  = '0;
        w_lo  = '1;
        w_sum = '0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            w_view[k] = (i_slot == SlotW'(k)) ? w_sel : r_ring[k];
            if (w_view[k] > w_hi) w_hi = w_view[k];
            if (w_view[k] < w_lo) w_lo = w_view[k];
            w_sum = w_sum + SumW'(w_view[k]);
        end
        w_diff = w_sum - SumW'(w_hi) - SumW'(w_lo);

        w_prod = ProdW'(w_diff) * ProdW'(TrimRecip);
        if (TrimPow2) begin
            w_quot = w_diff >> TrimShift;
        end else begin
            w_quot = w_prod[RecipShift +: SumW];
        end

        o_mean = (w_quot > SumW'(MeanMax)) ? MeanMax : w_quot[DataW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_last <= '0;
        end else if (i_load) begin
            r_ring[i_slot] <= w_sel;
            r_last         <= w_sel;
        end
    end

endmodule

>>> design/rptm_merge.sv
// ----------------------------------------------------------------------------
// rptm_merge
// Merges lane means into one result: channel reorder, flight-mode hysteresis
// on the previous aux1 mean, and a two-deep output register with skid.
// ----------------------------------------------------------------------------
module rptm_merge import rptm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_sample i_mean [NumCh],
    input  t_cfg    i_cfg,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_result o_res
);

    t_sample r_prev_aux1;
    logic    r_mode;
    logic    n_mode;
    t_result w_res;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    always_comb begin
        // low test first, high test second: clearing wins on inverted limits
        n_mode = r_mode;
        if (r_prev_aux1 < i_cfg.mode_low)  n_mode = 1'b1;
        if (r_prev_aux1 > i_cfg.mode_high) n_mode = 1'b0;

        w_res.roll        = i_mean[CH_ROLL];
        w_res.pitch       = i_mean[CH_PITCH];
        w_res.yaw         = i_mean[CH_YAW];
        w_res.throttle    = i_mean[CH_THROTTLE];
        w_res.aux1        = i_mean[CH_AUX1];
        w_res.aux2        = i_mean[CH_AUX2];
        w_res.flight_mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_aux1 <= '0;
            r_mode      <= 1'b0;
        end else if (i_load) begin
            r_prev_aux1 <= i_mean[CH_AUX1];
            r_mode      <= n_mode;
        end
    end

    // skid only fills when the output register is held by the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_load) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end else if (i_out_ready && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

>>> design/rc_pulse_trimmed_mean_filter_top.sv
// Each result is registered in the output register, or the skid if that is held.
// One frame per cycle unless stalled; six lanes filter all channels in parallel.
// Input ready drops only when both the output register and skid stage are full.
// Reset (synchronous, active low) zeroes sample rings, last-accepted values,
// ring slot, previous aux1 and mode bit, and restores the register defaults.
// ----------------------------------------------------------------------------
// rc_pulse_trimmed_mean_filter_top
// Six-channel RC pulse filter: window check, four-sample trimmed mean per
// channel, flight-mode hysteresis, configuration registers.
// ----------------------------------------------------------------------------
module rc_pulse_trimmed_mean_filter_top import rptm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [DataW-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PulseW-1:0]  i_pulse_ch0,
    input  logic [PulseW-1:0]  i_pulse_ch1,
    input  logic [PulseW-1:0]  i_pulse_ch2,
    input  logic [PulseW-1:0]  i_pulse_ch3,
    input  logic [PulseW-1:0]  i_pulse_ch4,
    input  logic [PulseW-1:0]  i_pulse_ch5,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [DataW-1:0]   o_roll_out,
    output logic [DataW-1:0]   o_pitch_out,
    output logic [DataW-1:0]   o_yaw_out,
    output logic [DataW-1:0]   o_throttle_out,
    output logic [DataW-1:0]   o_aux1_out,
    output logic [DataW-1:0]   o_aux2_out,
    output logic               o_flight_mode
);

    t_cfg              r_cfg;
    logic [SlotW-1:0]  r_slot;
    logic [SlotW-1:0]  n_slot;
    logic              w_load;
    logic              w_in_ready;
    logic [PulseW-1:0] w_pulse [NumCh];
    t_sample           w_mean  [NumCh];
    t_result           w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_min <= ValidMinReset;
            r_cfg.valid_max <= ValidMaxReset;
            r_cfg.mode_low  <= ModeLowReset;
            r_cfg.mode_high <= ModeHighReset;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_VALID_MIN: r_cfg.valid_min <= i_cfg_data;
                CFG_VALID_MAX: r_cfg.valid_max <= i_cfg_data;
                CFG_MODE_LOW:  r_cfg.mode_low  <= i_cfg_data;
                CFG_MODE_HIGH: r_cfg.mode_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_load = i_in_valid && w_in_ready;

    // ring slot advances before each write
    assign n_slot = (r_slot == SlotW'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (w_load) begin
            r_slot <= n_slot;
        end
    end

    assign w_pulse[CH_ROLL]     = i_pulse_ch0;
    assign w_pulse[CH_PITCH]    = i_pulse_ch1;
    assign w_pulse[CH_THROTTLE] = i_pulse_ch2;
    assign w_pulse[CH_YAW]      = i_pulse_ch3;
    assign w_pulse[CH_AUX1]     = i_pulse_ch4;
    assign w_pulse[CH_AUX2]     = i_pulse_ch5;

    for (genvar g = 0; g < NumCh; g++) begin : g_lane
        rptm_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load),
            .i_slot  (n_slot),
            .i_cfg   (r_cfg),
            .i_pulse (w_pulse[g]),
            .o_mean  (w_mean[g])
        );
    end

    rptm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_mean      (w_mean),
        .i_cfg       (r_cfg),
        .i_out_ready (i_out_ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (o_out_valid),
        .o_res       (w_res)
    );

    assign o_in_ready     = w_in_ready;
    assign o_roll_out     = w_res.roll;
    assign o_pitch_out    = w_res.pitch;
    assign o_yaw_out      = w_res.yaw;
    assign o_throttle_out = w_res.throttle;
    assign o_aux1_out     = w_res.aux1;
    assign o_aux2_out     = w_res.aux2;
    assign o_flight_mode  = w_res.flight_mode;

endmodule

>>> design/rptm_checker.sv
// ----------------------------------------------------------------------------
// rptm_checker
// Port-level checks on the filter top: output handshake and skid behavior.
// ----------------------------------------------------------------------------
module rptm_checker import rptm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [DataW-1:0] o_aux1_out,
    input logic             o_flight_mode
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // a held result keeps its aux1 and flight-mode payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_aux1_out) && $stable(o_flight_mode))
        else $error("output payload changed while stalled");

    // a result only appears after an accepted frame
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without an accepted frame");

    // input backpressure only when a result is waiting; the skid may be
    // draining on this edge, so the consumer's ready is not constrained
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output stage not empty after reset");

endmodule

bind rc_pulse_trimmed_mean_filter_top rptm_checker u_rptm_checker (.*);
